[sv/gzhp_pkg.sv]
// ============================================================================
// gzhp_pkg
// Types, constants and helper functions shared by the gzip header parser.
// ============================================================================
package gzhp_pkg;

    typedef enum logic [3:0] {
        PH_MAGIC0  = 4'd0,
        PH_MAGIC1  = 4'd1,
        PH_METHOD  = 4'd2,
        PH_FLAGS   = 4'd3,
        PH_FIXED   = 4'd4,
        PH_XLEN0   = 4'd5,
        PH_XLEN1   = 4'd6,
        PH_XSKIP   = 4'd7,
        PH_NAME    = 4'd8,
        PH_COMMENT = 4'd9,
        PH_HCRC0   = 4'd10,
        PH_HCRC1   = 4'd11,
        PH_PAYLOAD = 4'd12,
        PH_EMAGIC  = 4'd13,
        PH_EMETHOD = 4'd14,
        PH_ECRC    = 4'd15
    } t_phase;

    typedef enum logic [2:0] {
        ST_HEADER     = 3'd0,
        ST_END        = 3'd1,
        ST_PAYLOAD    = 3'd2,
        ST_BAD_MAGIC  = 3'd3,
        ST_BAD_METHOD = 3'd4,
        ST_BAD_CRC    = 3'd5
    } t_status;

    typedef struct packed {
        logic restart;
        logic fold;
    } t_crc_ctrl;

    localparam logic [15:0] MAGIC      = 16'h8b1f;
    localparam logic [7:0]  METHOD_DEF = 8'd8;
    localparam logic [15:0] FIXED_LEN  = 16'd6;
    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;

    localparam int FL_HCRC    = 1;
    localparam int FL_EXTRA   = 2;
    localparam int FL_NAME    = 3;
    localparam int FL_COMMENT = 4;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in,
                                             input logic [7:0]  b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    function automatic t_phase after_section(input t_phase     from,
                                             input logic [7:0] flags);
        t_phase r;
        if (from == PH_FIXED && flags[FL_EXTRA]) begin
            r = PH_XLEN0;
        end else if ((from == PH_FIXED || from == PH_XSKIP) && flags[FL_NAME]) begin
            r = PH_NAME;
        end else if ((from == PH_FIXED || from == PH_XSKIP || from == PH_NAME)
                     && flags[FL_COMMENT]) begin
            r = PH_COMMENT;
        end else if (flags[FL_HCRC]) begin
            r = PH_HCRC0;
        end else begin
            r = PH_PAYLOAD;
        end
        return r;
    endfunction

endpackage

[sv/gzhp_crc.sv]
// ============================================================================
// gzhp_crc
// Running reflected CRC-32 over header bytes, one byte per request.
// ============================================================================
module gzhp_crc (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gzhp_pkg::t_crc_ctrl  i_ctrl,
    input  logic [7:0]           i_byte,
    output logic [15:0]          o_check
);

    logic [31:0] r_crc;
    logic [31:0] n_crc;
    logic [31:0] base;

    always_comb begin
        base = i_ctrl.restart ? gzhp_pkg::CRC_INIT : r_crc;
        if (i_ctrl.fold) begin
            n_crc = gzhp_pkg::crc_byte(base, i_byte);
        end else begin
            n_crc = base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= gzhp_pkg::CRC_INIT;
        end else begin
            r_crc <= n_crc;
        end
    end

    assign o_check = ~r_crc[15:0];

endmodule

[sv/gzip_header_parser_core.sv]
// ============================================================================
// gzip_header_parser_core
// Byte-wide gzip member header parser with sticky error reporting.
// ============================================================================
// Input channel: i_valid / o_stall carry one stream byte (i_byte_value) and
// i_restart, which marks the first byte of a new stream and clears the parser
// before that byte is examined.
// Output channel: o_valid / i_stall carry one result per input request:
// o_status (in header, header end, payload, bad magic, bad method, bad
// header CRC) and o_header_flags (flag byte seen so far, zero before it).
// Latency: the result of a request is presented on the cycle after it is
// accepted. Throughput: one byte per cycle; the phase update, skip counter
// and the byte-wide CRC-32 fold all settle in the single cycle of
// acceptance, and the result register takes a new request whenever it is
// empty or is being drained in the same cycle.
// Reset: the parser waits for the first magic byte, flags clear, the CRC
// register is all ones and the output register is empty.
// Stall: while i_stall holds a full output register, o_stall is raised and
// no input request is taken; the pending result stays unchanged.
// ============================================================================
module gzip_header_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_byte_value,
    input  logic        i_restart,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [7:0]  o_header_flags
);

    gzhp_pkg::t_phase    r_phase;
    gzhp_pkg::t_phase    n_phase;
    gzhp_pkg::t_phase    eff_phase;
    logic [7:0]          r_flags;
    logic [7:0]          n_flags;
    logic [7:0]          eff_flags;
    logic [7:0]          r_held;
    logic [7:0]          n_held;
    logic [15:0]         r_skip;
    logic [15:0]         n_skip;
    logic [15:0]         skip_dec;
    gzhp_pkg::t_status   n_status;
    logic                r_out_valid;
    logic [2:0]          r_out_status;
    logic [7:0]          r_out_flags;
    logic                acc;
    logic [15:0]         crc_check;
    gzhp_pkg::t_crc_ctrl crc_ctrl;

    assign o_stall = r_out_valid && i_stall;
    assign acc     = i_valid && !o_stall;

    assign crc_ctrl.restart = acc && i_restart;
    assign crc_ctrl.fold    = acc && (eff_phase < gzhp_pkg::PH_HCRC0);

    gzhp_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (crc_ctrl),
        .i_byte  (i_byte_value),
        .o_check (crc_check)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= gzhp_pkg::PH_MAGIC0;
            r_flags <= 8'd0;
            r_held  <= 8'd0;
            r_skip  <= 16'd0;
        end else if (acc) begin
            r_phase <= n_phase;
            r_flags <= n_flags;
            r_held  <= n_held;
            r_skip  <= n_skip;
        end
    end

    always_comb begin
        eff_phase = i_restart ? gzhp_pkg::PH_MAGIC0 : r_phase;
        eff_flags = i_restart ? 8'd0 : r_flags;
        n_phase   = eff_phase;
        n_flags   = eff_flags;
        n_held    = r_held;
        n_skip    = r_skip;
        skip_dec  = r_skip - 16'd1;
        n_status  = gzhp_pkg::ST_HEADER;

        unique case (eff_phase)
            gzhp_pkg::PH_MAGIC0: begin
                n_held  = i_byte_value;
                n_phase = gzhp_pkg::PH_MAGIC1;
            end
            gzhp_pkg::PH_MAGIC1: begin
                n_phase = ({i_byte_value, r_held} == gzhp_pkg::MAGIC) ?
                          gzhp_pkg::PH_METHOD : gzhp_pkg::PH_EMAGIC;
            end
            gzhp_pkg::PH_METHOD: begin
                n_phase = (i_byte_value == gzhp_pkg::METHOD_DEF) ?
                          gzhp_pkg::PH_FLAGS : gzhp_pkg::PH_EMETHOD;
            end
            gzhp_pkg::PH_FLAGS: begin
                n_flags = i_byte_value;
                n_skip  = gzhp_pkg::FIXED_LEN;
                n_phase = gzhp_pkg::PH_FIXED;
            end
            gzhp_pkg::PH_FIXED: begin
                n_skip = skip_dec;
                if (skip_dec == 16'd0) begin
                    n_phase = gzhp_pkg::after_section(gzhp_pkg::PH_FIXED, eff_flags);
                end
            end
            gzhp_pkg::PH_XLEN0: begin
                n_held  = i_byte_value;
                n_phase = gzhp_pkg::PH_XLEN1;
            end
            gzhp_pkg::PH_XLEN1: begin
                n_skip = {i_byte_value, r_held};
                if ({i_byte_value, r_held} == 16'd0) begin
                    n_phase = gzhp_pkg::after_section(gzhp_pkg::PH_XSKIP, eff_flags);
                end else begin
                    n_phase = gzhp_pkg::PH_XSKIP;
                end
            end
            gzhp_pkg::PH_XSKIP: begin
                n_skip = skip_dec;
                if (skip_dec == 16'd0) begin
                    n_phase = gzhp_pkg::after_section(gzhp_pkg::PH_XSKIP, eff_flags);
                end
            end
            gzhp_pkg::PH_NAME: begin
                if (i_byte_value == 8'd0) begin
                    n_phase = gzhp_pkg::after_section(gzhp_pkg::PH_NAME, eff_flags);
                end
            end
            gzhp_pkg::PH_COMMENT: begin
                if (i_byte_value == 8'd0) begin
                    n_phase = gzhp_pkg::after_section(gzhp_pkg::PH_COMMENT, eff_flags);
                end
            end
            gzhp_pkg::PH_HCRC0: begin
                n_held  = i_byte_value;
                n_phase = gzhp_pkg::PH_HCRC1;
            end
            gzhp_pkg::PH_HCRC1: begin
                n_phase = ({i_byte_value, r_held} == crc_check) ?
                          gzhp_pkg::PH_PAYLOAD : gzhp_pkg::PH_ECRC;
            end
            gzhp_pkg::PH_PAYLOAD: begin
                n_status = gzhp_pkg::ST_PAYLOAD;
            end
            default: begin
            end
        endcase

        priority if (n_phase == gzhp_pkg::PH_EMAGIC) begin
            n_status = gzhp_pkg::ST_BAD_MAGIC;
        end else if (n_phase == gzhp_pkg::PH_EMETHOD) begin
            n_status = gzhp_pkg::ST_BAD_METHOD;
        end else if (n_phase == gzhp_pkg::PH_ECRC) begin
            n_status = gzhp_pkg::ST_BAD_CRC;
        end else if (eff_phase != gzhp_pkg::PH_PAYLOAD
                     && n_phase == gzhp_pkg::PH_PAYLOAD) begin
            n_status = gzhp_pkg::ST_END;
        end else begin
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_out_status <= n_status;
            r_out_flags  <= n_flags;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_header_flags = r_out_flags;

    a_restart_to_magic1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_restart |=> r_phase == gzhp_pkg::PH_MAGIC1)
        else $error("restart did not move parser to second magic byte");

    a_flags_clear_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == gzhp_pkg::PH_MAGIC1 || r_phase == gzhp_pkg::PH_METHOD
        |-> r_flags == 8'd0)
        else $error("flags set before the flag byte");

    a_end_enters_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && n_status == gzhp_pkg::ST_END |=> r_phase == gzhp_pkg::PH_PAYLOAD)
        else $error("header end without payload phase");

    a_payload_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && !i_restart && r_phase == gzhp_pkg::PH_PAYLOAD
        |=> o_valid && o_status == gzhp_pkg::ST_PAYLOAD)
        else $error("payload byte not reported as payload");

endmodule

[test/gzip_header_parser_core_tb.sv]
// ============================================================================
// gzip_header_parser_core_tb
// Self-checking bench for the byte-wide gzip member header parser. A queue of
// stream bytes holds well-formed headers with random flags, names, comments
// and extra fields, faulty and truncated headers, and noise. Each accepted
// byte is run through a local parser model, and the status and flag byte of
// every result are checked in order against it. Both sides idle and stall at
// random.
// ============================================================================
module gzip_header_parser_core_tb;

    typedef struct {
        logic [7:0] value;
        logic       restart;
        logic       hold;
    } t_stream_byte;

    typedef struct {
        gzhp_pkg::t_status status;
        logic [7:0]        flags;
    } t_verdict;

    typedef enum {FAULT_NONE, FAULT_MAGIC, FAULT_METHOD, FAULT_CRC} t_fault;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_byte_value = 8'd0;
    logic       i_restart = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [2:0] o_status;
    logic [7:0] o_header_flags;

    t_stream_byte byte_q[$];
    t_verdict     verdict_q[$];
    int           stream_total = 0;
    int           sent_count = 0;
    int           mismatches = 0;
    logic         req_taken = 1'b0;
    logic         hold_next = 1'b0;

    gzhp_pkg::t_phase prs_phase = gzhp_pkg::PH_MAGIC0;
    logic [7:0]       prs_low = 8'd0;
    logic [15:0]      prs_skip = 16'd0;
    logic [7:0]       prs_flags = 8'd0;
    logic [31:0]      prs_crc = gzhp_pkg::CRC_INIT;

    gzip_header_parser_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_byte_value   (i_byte_value),
        .i_restart      (i_restart),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_header_flags (o_header_flags)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [31:0] crc32_step(input logic [31:0] acc,
                                               input logic [7:0]  b);
        logic [31:0] c;
        int i;
        c = acc;
        for (i = 0; i < 8; i++) begin
            if (c[0] ^ b[i]) begin
                c = (c >> 1) ^ gzhp_pkg::CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic gzhp_pkg::t_phase section_after(input gzhp_pkg::t_phase done,
                                                       input logic [7:0] fl);
        gzhp_pkg::t_phase r;
        r = fl[gzhp_pkg::FL_HCRC] ? gzhp_pkg::PH_HCRC0 : gzhp_pkg::PH_PAYLOAD;
        if (done != gzhp_pkg::PH_COMMENT && fl[gzhp_pkg::FL_COMMENT])
            r = gzhp_pkg::PH_COMMENT;
        if ((done == gzhp_pkg::PH_FIXED || done == gzhp_pkg::PH_XSKIP)
            && fl[gzhp_pkg::FL_NAME])
            r = gzhp_pkg::PH_NAME;
        if (done == gzhp_pkg::PH_FIXED && fl[gzhp_pkg::FL_EXTRA]) r = gzhp_pkg::PH_XLEN0;
        return r;
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic rs,
                              output gzhp_pkg::t_status st, output logic [7:0] fl);
        gzhp_pkg::t_phase nxt;
        if (rs) begin
            prs_phase = gzhp_pkg::PH_MAGIC0;
            prs_low   = 8'd0;
            prs_skip  = 16'd0;
            prs_flags = 8'd0;
            prs_crc   = gzhp_pkg::CRC_INIT;
        end
        nxt = prs_phase;
        st  = gzhp_pkg::ST_HEADER;
        if (prs_phase < gzhp_pkg::PH_HCRC0) prs_crc = crc32_step(prs_crc, b);
        case (prs_phase)
            gzhp_pkg::PH_MAGIC0: begin
                prs_low = b;
                nxt = gzhp_pkg::PH_MAGIC1;
            end
            gzhp_pkg::PH_MAGIC1:
                nxt = ({b, prs_low} == gzhp_pkg::MAGIC) ? gzhp_pkg::PH_METHOD
                                                        : gzhp_pkg::PH_EMAGIC;
            gzhp_pkg::PH_METHOD:
                nxt = (b == gzhp_pkg::METHOD_DEF) ? gzhp_pkg::PH_FLAGS
                                                  : gzhp_pkg::PH_EMETHOD;
            gzhp_pkg::PH_FLAGS: begin
                prs_flags = b;
                prs_skip = gzhp_pkg::FIXED_LEN;
                nxt = gzhp_pkg::PH_FIXED;
            end
            gzhp_pkg::PH_FIXED, gzhp_pkg::PH_XSKIP: begin
                prs_skip = prs_skip - 16'd1;
                if (prs_skip == 16'd0) nxt = section_after(prs_phase, prs_flags);
            end
            gzhp_pkg::PH_XLEN0, gzhp_pkg::PH_HCRC0: begin
                prs_low = b;
                nxt = (prs_phase == gzhp_pkg::PH_XLEN0) ? gzhp_pkg::PH_XLEN1
                                                        : gzhp_pkg::PH_HCRC1;
            end
            gzhp_pkg::PH_XLEN1: begin
                prs_skip = {b, prs_low};
                nxt = (prs_skip == 16'd0) ? section_after(gzhp_pkg::PH_XSKIP, prs_flags)
                                          : gzhp_pkg::PH_XSKIP;
            end
            gzhp_pkg::PH_NAME, gzhp_pkg::PH_COMMENT: begin
                if (b == 8'd0) nxt = section_after(prs_phase, prs_flags);
            end
            gzhp_pkg::PH_HCRC1:
                nxt = ({b, prs_low} == ~prs_crc[15:0]) ? gzhp_pkg::PH_PAYLOAD
                                                        : gzhp_pkg::PH_ECRC;
            gzhp_pkg::PH_PAYLOAD: st = gzhp_pkg::ST_PAYLOAD;
            default: ;
        endcase
        if (prs_phase != gzhp_pkg::PH_PAYLOAD && nxt == gzhp_pkg::PH_PAYLOAD)
            st = gzhp_pkg::ST_END;
        case (nxt)
            gzhp_pkg::PH_EMAGIC:  st = gzhp_pkg::ST_BAD_MAGIC;
            gzhp_pkg::PH_EMETHOD: st = gzhp_pkg::ST_BAD_METHOD;
            gzhp_pkg::PH_ECRC:    st = gzhp_pkg::ST_BAD_CRC;
            default: ;
        endcase
        prs_phase = nxt;
        fl = prs_flags;
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic add_byte(input logic [7:0] v, input logic rs);
        t_stream_byte e;
        e.value   = v;
        e.restart = rs;
        e.hold    = hold_next;
        hold_next = 1'b0;
        byte_q.push_back(e);
    endtask

    task automatic emit_header(input logic [7:0] flags, input logic [15:0] xlen,
                               input int name_len, input int cmt_len, input t_fault fault,
                               input int keep, input int payload_len, input logic rs);
        logic [7:0]  hdr[$];
        logic [31:0] crc;
        logic [15:0] hcrc;
        int          n;
        hdr = {};
        if (fault == FAULT_CRC) flags[gzhp_pkg::FL_HCRC] = 1'b1;
        hdr.push_back(gzhp_pkg::MAGIC[7:0]);
        hdr.push_back(gzhp_pkg::MAGIC[15:8]);
        hdr.push_back(gzhp_pkg::METHOD_DEF);
        hdr.push_back(flags);
        repeat (6) hdr.push_back(8'($urandom));
        if (flags[gzhp_pkg::FL_EXTRA]) begin
            hdr.push_back(xlen[7:0]);
            hdr.push_back(xlen[15:8]);
            repeat (int'(xlen)) hdr.push_back(8'($urandom));
        end
        if (flags[gzhp_pkg::FL_NAME]) begin
            repeat (name_len) hdr.push_back(8'($urandom_range(1, 255)));
            hdr.push_back(8'd0);
        end
        if (flags[gzhp_pkg::FL_COMMENT]) begin
            repeat (cmt_len) hdr.push_back(8'($urandom_range(1, 255)));
            hdr.push_back(8'd0);
        end
        if (fault == FAULT_MAGIC) begin
            if ($urandom_range(1))
                hdr[0] = gzhp_pkg::MAGIC[7:0] ^ 8'($urandom_range(1, 255));
            else
                hdr[1] = gzhp_pkg::MAGIC[15:8] ^ 8'($urandom_range(1, 255));
        end
        if (fault == FAULT_METHOD)
            hdr[2] = gzhp_pkg::METHOD_DEF ^ 8'($urandom_range(1, 255));
        crc = gzhp_pkg::CRC_INIT;
        foreach (hdr[i]) crc = crc32_step(crc, hdr[i]);
        if (flags[gzhp_pkg::FL_HCRC]) begin
            hcrc = ~crc[15:0];
            if (fault == FAULT_CRC) hcrc = hcrc ^ (16'd1 << $urandom_range(15));
            hdr.push_back(hcrc[7:0]);
            hdr.push_back(hcrc[15:8]);
        end
        n = (keep > 0 && keep < hdr.size()) ? keep : hdr.size();
        for (int i = 0; i < n; i++) add_byte(hdr[i], (i == 0) ? rs : 1'b0);
        if (n == hdr.size()) repeat (payload_len) add_byte(8'($urandom), 1'b0);
    endtask

    always @(posedge i_clk) begin
        t_verdict want;
        t_verdict got;
        if (!i_rst_n) begin
            req_taken = 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result status=%0d flags=%02h",
                                              o_status, o_header_flags));
                end else begin
                    want = verdict_q.pop_front();
                    if (o_status !== want.status)
                        report_mismatch($sformatf("status %0d, wanted %0d",
                                                  o_status, want.status));
                    if (o_header_flags !== want.flags)
                        report_mismatch($sformatf("header_flags %02h, wanted %02h",
                                                  o_header_flags, want.flags));
                end
            end
            req_taken = i_valid && !o_stall;
            if (req_taken) begin
                parse_byte(i_byte_value, i_restart, got.status, got.flags);
                verdict_q.push_back(got);
                sent_count++;
            end
        end
    end

    always @(negedge i_clk) begin
        t_stream_byte nb;
        int send_idle;
        int recv_idle;
        send_idle = 0;
        recv_idle = 0;
        if (sent_count < stream_total / 3) begin
            send_idle = 29;
            recv_idle = 52;
        end else if (sent_count < 2 * stream_total / 3) begin
            send_idle = 52;
            recv_idle = 29;
        end
        if (i_rst_n && !(i_valid && !req_taken)) begin
            if (byte_q.size() > 0 && !(byte_q[0].hold && verdict_q.size() != 0)
                && $urandom_range(99) >= send_idle) begin
                nb = byte_q.pop_front();
                i_valid      <= 1'b1;
                i_byte_value <= nb.value;
                i_restart    <= nb.restart;
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_stall <= i_rst_n && ($urandom_range(99) < recv_idle);
    end

    initial begin
        #2000000;
        $display("gzip_header_parser_core: mismatch");
        $finish;
    end

    initial begin
        int headers;
        int pick;
        int drain;
        logic [15:0] xlen;

        // directed: plain header straight after reset, then each section and fault
        emit_header(8'h00, 16'd0, 0, 0, FAULT_NONE, 0, 2, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'hff, 1'b0);
        emit_header(8'h1e, 16'd3, 2, 1, FAULT_NONE, 0, 1, 1'b1);
        emit_header(8'h06, 16'd0, 0, 0, FAULT_NONE, 0, 1, 1'b1);
        emit_header(8'hff, 16'd1, 0, 0, FAULT_NONE, 0, 1, 1'b1);
        emit_header(8'he1, 16'd0, 0, 0, FAULT_NONE, 0, 1, 1'b1);
        emit_header(8'h00, 16'd0, 0, 0, FAULT_MAGIC, 0, 2, 1'b1);
        emit_header(8'h1c, 16'd2, 1, 1, FAULT_METHOD, 0, 2, 1'b1);
        emit_header(8'h1a, 16'd0, 1, 0, FAULT_CRC, 0, 2, 1'b1);

        // random: mostly well-formed, some faulty, truncated or noise
        headers = 0;
        while (byte_q.size() < 520) begin
            if (headers % 12 == 0) hold_next = 1'b1;
            pick = $urandom_range(99);
            xlen = ($urandom_range(39) == 0) ? 16'($urandom_range(256, 300))
                                             : 16'($urandom_range(0, 5));
            if (pick < 72) begin
                emit_header(8'($urandom), xlen, $urandom_range(0, 4), $urandom_range(0, 4),
                            FAULT_NONE, 0, $urandom_range(0, 4), 1'b1);
            end else if (pick < 88) begin
                emit_header(8'($urandom), xlen, $urandom_range(0, 3), $urandom_range(0, 3),
                            t_fault'($urandom_range(1, 3)), 0, $urandom_range(0, 3), 1'b1);
            end else if (pick < 95) begin
                emit_header(8'($urandom), xlen, $urandom_range(0, 3), $urandom_range(0, 3),
                            FAULT_NONE, $urandom_range(1, 14), 0, 1'b1);
            end else begin
                repeat ($urandom_range(1, 6)) add_byte(8'($urandom), $urandom_range(7) == 0);
            end
            headers++;
        end
        stream_total = byte_q.size();

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (sent_count < stream_total) @(posedge i_clk);
        drain = 0;
        while (verdict_q.size() != 0 && drain < 1000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (4) @(posedge i_clk);
        if (verdict_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", verdict_q.size()));

        if (mismatches == 0) begin
            $display("gzip_header_parser_core: match");
        end else begin
            $display("gzip_header_parser_core: mismatch");
        end
        $finish;
    end

endmodule

[gzip_header_parser_core.f]
sv/gzhp_pkg.sv
sv/gzhp_crc.sv
sv/gzip_header_parser_core.sv
test/gzip_header_parser_core_tb.sv
